### hdl/mbps_pkg.sv
package mbps_pkg;

   localparam int MAX_PATTERN_DEFAULT  = 32;
   localparam int ADDRESS_BITS_DEFAULT = 48;

   // pattern storage is fixed by the register map: four 64-bit words of bytes
   localparam int PATTERN_WORDS  = 4;
   localparam int PATTERN_SLOTS  = 32;
   localparam int WORD_BITS      = 64;
   localparam int CARE_BITS      = 32;
   localparam int LENGTH_BITS    = 6;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_BYTE   = 2'd1,
      CMD_REGION = 2'd2,
      CMD_END    = 2'd3
   } command_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_BYTES_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_BYTES_1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_BYTES_2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_BYTES_3 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CARE_MASK       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH  = 3'd5;

   typedef struct packed {
      logic [PATTERN_SLOTS-1:0][7:0] pattern;
      logic [CARE_BITS-1:0]          care;
      logic [LENGTH_BITS-1:0]        length;
   } cfg_type;

   typedef struct packed {
      logic shift;    // take the byte into the window
      logic region;   // byte opens a new region
      logic restart;  // start of scan, drop the window
   } win_ctl_type;

endpackage

### hdl/mbps_req_if.sv
interface mbps_req_if
   import mbps_pkg::*;
#(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) ();
   logic                    valid;
   logic                    ready;
   command_type             command;
   logic [7:0]              data_byte;
   logic [ADDRESS_BITS-1:0] byte_address;

   modport source (output valid, command, data_byte, byte_address, input ready);
   modport sink   (input valid, command, data_byte, byte_address, output ready);
endinterface

### hdl/mbps_rsp_if.sv
interface mbps_rsp_if
   import mbps_pkg::*;
#(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) ();
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [ADDRESS_BITS-1:0] match_address;

   modport source (output valid, found, match_address, input ready);
   modport sink   (input valid, found, match_address, output ready);
endinterface

### hdl/mbps_cfg_regs.sv
module mbps_cfg_regs
   import mbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg
);

   logic [PATTERN_WORDS-1:0][WORD_BITS-1:0] pattern_ff;
   logic [CARE_BITS-1:0]                    care_ff;
   logic [LENGTH_BITS-1:0]                  length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= '0;
         length_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PATTERN_BYTES_0: pattern_ff[0] <= csr_data[WORD_BITS-1:0];
            REG_PATTERN_BYTES_1: pattern_ff[1] <= csr_data[WORD_BITS-1:0];
            REG_PATTERN_BYTES_2: pattern_ff[2] <= csr_data[WORD_BITS-1:0];
            REG_PATTERN_BYTES_3: pattern_ff[3] <= csr_data[WORD_BITS-1:0];
            REG_CARE_MASK:       care_ff       <= csr_data[CARE_BITS-1:0];
            REG_PATTERN_LENGTH:  length_ff     <= csr_data[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // byte k of the pattern sits at bit 8k of the concatenated words
   assign cfg.pattern = pattern_ff;
   assign cfg.care    = care_ff;
   assign cfg.length  = length_ff;

endmodule

### hdl/mbps_window.sv
module mbps_window
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int FILL_BITS   = $clog2(MAX_PATTERN + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  win_ctl_type                 ctl,
   input  logic [7:0]                  data_byte,
   output logic [MAX_PATTERN-1:0][7:0] window_next,
   output logic [FILL_BITS-1:0]        fill_next
);

   logic [MAX_PATTERN-1:0][7:0] window_ff;
   logic [FILL_BITS-1:0]        fill_ff;
   logic [FILL_BITS-1:0]        fill_base;

   // entry 0 is the newest byte
   always_comb begin
      window_next[0] = data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_next[i] = window_ff[i-1];
      end
   end

   always_comb begin
      fill_base = ctl.region ? '0 : fill_ff;
      fill_next = (fill_base == FILL_BITS'(MAX_PATTERN)) ? fill_base
                                                         : fill_base + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (ctl.restart) begin
         fill_ff <= '0;
      end else if (ctl.shift) begin
         fill_ff <= fill_next;
      end
   end

   // contents past the fill count are never compared
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         window_ff <= window_next;
      end
   end

endmodule

### hdl/mbps_match.sv
module mbps_match
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int FILL_BITS   = $clog2(MAX_PATTERN + 1)
) (
   input  cfg_type                     cfg,
   input  logic [MAX_PATTERN-1:0][7:0] window,
   input  logic [FILL_BITS-1:0]        fill,
   output logic                        hit
);

   logic                   length_ok;
   logic                   miss;
   logic [LENGTH_BITS-1:0] k;

   // window entry j lines up with pattern byte length-1-j
   always_comb begin
      length_ok = (cfg.length != '0) &&
                  (cfg.length <= LENGTH_BITS'(MAX_PATTERN)) &&
                  (LENGTH_BITS'(fill) >= cfg.length);
      miss = 1'b0;
      k    = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         k = cfg.length - LENGTH_BITS'(j) - 1'b1;
         if ((LENGTH_BITS'(j) < cfg.length) && cfg.care[k[4:0]] &&
             (window[j] != cfg.pattern[k[4:0]])) begin
            miss = 1'b1;
         end
      end
      hit = length_ok && !miss;
   end

endmodule

### hdl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner. Memory bytes stream in one transaction per cycle with
// their addresses; each byte is shifted into a window of the current region and the
// newest pattern_length bytes are compared in parallel against the configured
// pattern, skipping bytes whose care bit is clear. The first match returns found=1
// with the address of the window's first byte, after which bytes are ignored until
// the next start command; an end command without a match returns found=0, address
// zero. The block sustains one byte per cycle while the receiver takes results. The
// full-window masked compare feeding the result register sets the clock period.
// Write configuration only while no transaction is in flight.
module masked_byte_pattern_scanner
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN  = MAX_PATTERN_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   mbps_req_if.sink                  req_chan,
   mbps_rsp_if.source                rsp_chan
);

   localparam int FILL_BITS = $clog2(MAX_PATTERN + 1);

   cfg_type                     cfg;
   win_ctl_type                 win_ctl;
   logic [MAX_PATTERN-1:0][7:0] window_next;
   logic [FILL_BITS-1:0]        fill_next;
   logic                        hit;

   logic                    in_valid_ff, in_valid_in;
   command_type             in_cmd_ff;
   logic [7:0]              in_data_ff;
   logic [ADDRESS_BITS-1:0] in_addr_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [ADDRESS_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic                    done_ff, done_in;

   logic out_free;
   logic step;
   logic is_byte;
   logic produce;

   mbps_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbps_window #(
      .MAX_PATTERN (MAX_PATTERN),
      .FILL_BITS   (FILL_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .ctl         (win_ctl),
      .data_byte   (in_data_ff),
      .window_next (window_next),
      .fill_next   (fill_next)
   );

   mbps_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .FILL_BITS   (FILL_BITS)
   ) u_match (
      .cfg    (cfg),
      .window (window_next),
      .fill   (fill_next),
      .hit    (hit)
   );

   // the held item moves on whenever the result slot is empty or draining
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_comb begin
      is_byte = (in_cmd_ff == CMD_BYTE) || (in_cmd_ff == CMD_REGION);

      win_ctl.shift   = step && is_byte && !done_ff;
      win_ctl.region  = (in_cmd_ff == CMD_REGION);
      win_ctl.restart = step && (in_cmd_ff == CMD_START);

      produce = step && !done_ff && ((in_cmd_ff == CMD_END) || (is_byte && hit));

      in_valid_in = req_chan.ready ? req_chan.valid : in_valid_ff;

      done_in = done_ff;
      if (step) begin
         if (in_cmd_ff == CMD_START) begin
            done_in = 1'b0;
         end else if (produce) begin
            done_in = 1'b1;
         end
      end

      rsp_valid_in = out_free ? produce : rsp_valid_ff;
      rsp_found_in = is_byte;
      rsp_addr_in  = is_byte ? in_addr_ff - (ADDRESS_BITS'(cfg.length) - 1'b1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_cmd_ff  <= req_chan.command;
         in_data_ff <= req_chan.data_byte;
         in_addr_ff <= req_chan.byte_address;
      end
      if (produce) begin
         rsp_found_ff <= rsp_found_in;
         rsp_addr_ff  <= rsp_addr_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.match_address = rsp_addr_ff;

   // one result per scan: emitting one closes the scan
   a_result_closes_scan: assert property (@(posedge clock) disable iff (reset)
      produce |=> done_ff)
      else $error("result issued but scan not marked done");

   a_not_found_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_addr_ff == '0))
      else $error("not-found result with nonzero address");

   a_start_reopens: assert property (@(posedge clock) disable iff (reset)
      (step && (in_cmd_ff == CMD_START)) |=> !done_ff)
      else $error("start command did not reopen the scan");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      win_ctl.shift |-> (fill_next <= FILL_BITS'(MAX_PATTERN)))
      else $error("window fill beyond window depth");

endmodule

### sim/masked_byte_pattern_scanner_tb.sv
typedef struct packed {
   logic                                     found;
   logic [mbps_pkg::ADDRESS_BITS_DEFAULT-1:0] addr;
} scan_result_t;

class scan_scoreboard;
   localparam int ADDR_W = mbps_pkg::ADDRESS_BITS_DEFAULT;
   localparam int WIN_DEPTH = mbps_pkg::MAX_PATTERN_DEFAULT;

   logic [7:0]  pat [mbps_pkg::PATTERN_SLOTS];
   logic [31:0] care;
   logic [5:0]  plen;
   logic [7:0]  win [WIN_DEPTH];
   int          fill;
   bit          done;

   scan_result_t exp_q[$];
   int errors;
   int accepted;
   int results;
   int match_count;

   function new();
      foreach (pat[k]) pat[k] = '0;
      foreach (win[k]) win[k] = '0;
      care        = '0;
      plen        = '0;
      fill        = 0;
      done        = 1'b0;
      errors      = 0;
      accepted    = 0;
      results     = 0;
      match_count = 0;
   endfunction

   function int pending();
      return exp_q.size();
   endfunction

   function void write_reg(logic [2:0] idx, logic [63:0] val);
      if (idx <= mbps_pkg::REG_PATTERN_BYTES_3) begin
         for (int k = 0; k < 8; k++) pat[8*idx + k] = val[8*k +: 8];
      end else if (idx == mbps_pkg::REG_CARE_MASK) begin
         care = val[31:0];
      end else if (idx == mbps_pkg::REG_PATTERN_LENGTH) begin
         plen = val[5:0];
      end
   endfunction

   // newest byte sits in win[0]; pattern byte 0 lines up with the oldest byte
   function bit window_hit();
      if (plen == 0 || plen > WIN_DEPTH || fill < plen) return 1'b0;
      for (int k = 0; k < plen; k++) begin
         if (care[k] && win[plen - 1 - k] != pat[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function void note_input(mbps_pkg::command_type cmd, logic [7:0] data,
                            logic [ADDR_W-1:0] addr);
      scan_result_t r;
      accepted++;
      if (cmd == mbps_pkg::CMD_START) begin
         fill = 0;
         done = 1'b0;
         return;
      end
      if (done) return;
      if (cmd == mbps_pkg::CMD_END) begin
         done = 1'b1;
         r.found = 1'b0;
         r.addr  = '0;
         exp_q.insert(exp_q.size(), r);
         return;
      end
      if (cmd == mbps_pkg::CMD_REGION) fill = 0;
      for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = data;
      if (fill < WIN_DEPTH) fill++;
      if (window_hit()) begin
         done = 1'b1;
         r.found = 1'b1;
         r.addr  = addr - ADDR_W'(plen) + ADDR_W'(1);
         exp_q.insert(exp_q.size(), r);
      end
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_result(logic found, logic [ADDR_W-1:0] addr);
      scan_result_t e;
      results++;
      if (found === 1'b1) match_count++;
      if (exp_q.size() == 0) begin
         report($sformatf("unexpected result found=%0b addr=%h", found, addr));
         return;
      end
      e = exp_q.pop_front();
      if (found !== e.found)
         report($sformatf("found %0b, predicted %0b", found, e.found));
      if (addr !== e.addr)
         report($sformatf("match_address %h, predicted %h", addr, e.addr));
   endtask
endclass

module masked_byte_pattern_scanner_tb;
   import mbps_pkg::*;

   localparam int ADDR_W       = ADDRESS_BITS_DEFAULT;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 120;
   localparam int PRESSURE_PHASE = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      command_type       cmd;
      logic [7:0]        data;
      logic [ADDR_W-1:0] addr;
   } scan_item_t;

   logic clock = 1'b0;
   logic reset;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   mbps_req_if #(.ADDRESS_BITS(ADDR_W)) req_bus ();
   mbps_rsp_if #(.ADDRESS_BITS(ADDR_W)) rsp_bus ();

   masked_byte_pattern_scanner u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   scan_scoreboard sb = new();
   scan_item_t     stim_q[$];

   // generator's copy of the active pattern
   logic [7:0]  gen_pat [PATTERN_SLOTS];
   logic [31:0] gen_care;
   int          gen_len;
   int          config_count = 0;

   int rsp_stall_pct = 0;
   int rsp_hold_len  = 0;
   int quiet_cycles  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      reset               <= 1'b1;
      csr_write           <= 1'b0;
      csr_index           <= '0;
      csr_data            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_START;
      req_bus.data_byte    <= '0;
      req_bus.byte_address <= '0;
      rsp_bus.ready        <= 1'b0;
   end

   // receiver: random backpressure, plus an occasional long hold-off
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_input(req_bus.command, req_bus.data_byte, req_bus.byte_address);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.found, rsp_bus.match_address);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_W-1:0];
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic void push(command_type cmd, logic [7:0] data, logic [ADDR_W-1:0] addr);
      scan_item_t it;
      it.cmd  = cmd;
      it.data = data;
      it.addr = addr;
      stim_q.insert(stim_q.size(), it);
   endfunction

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_config(input logic [63:0] words [4], input logic [31:0] care,
                               input logic [5:0] len);
      write_csr(REG_PATTERN_BYTES_0, words[0]);
      write_csr(REG_PATTERN_BYTES_1, words[1]);
      write_csr(REG_PATTERN_BYTES_2, words[2]);
      write_csr(REG_PATTERN_BYTES_3, words[3]);
      write_csr(REG_CARE_MASK, 64'(care));
      write_csr(REG_PATTERN_LENGTH, 64'(len));
      // unmapped index must leave everything alone
      write_csr($urandom_range(1) ? CSR_SPARE_6 : CSR_SPARE_7, {$urandom, $urandom});
      csr_write <= 1'b0;
      for (int k = 0; k < PATTERN_SLOTS; k++) gen_pat[k] = words[k/8][8*(k%8) +: 8];
      gen_care = care;
      gen_len  = len;
      config_count++;
   endtask

   task automatic drive_items(int idle_pct);
      scan_item_t it;
      while (stim_q.size() > 0) begin
         it = stim_q.pop_front();
         while ($urandom_range(99) < idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
         req_bus.valid        <= 1'b1;
         req_bus.command      <= it.cmd;
         req_bus.data_byte    <= it.data;
         req_bus.byte_address <= it.addr;
         do @(posedge clock); while (!req_bus.ready);
      end
      req_bus.valid <= 1'b0;
   endtask

   // first let the monitor note the last accepted transaction, then wait for no pending result
   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one scan: usually a start, one to three regions (some with the pattern planted), usually an end, maybe noise
   task automatic gen_scan(bit short_regions);
      int nreg, rl, p, span;
      bit plant;
      logic [ADDR_W-1:0] base;
      logic [7:0] b;
      command_type cmd;
      if ($urandom_range(99) < 95) push(CMD_START, rand_byte(), rand_addr());
      nreg = $urandom_range(1, 3);
      span = (gen_len >= 1 && gen_len <= PATTERN_SLOTS) ? gen_len : 4;
      for (int r = 0; r < nreg; r++) begin
         if ($urandom_range(9) == 0) base = '1 - ADDR_W'($urandom_range(40));
         else base = rand_addr();
         plant = !short_regions && gen_len >= 1 && gen_len <= PATTERN_SLOTS
                 && $urandom_range(1);
         rl = short_regions ? $urandom_range(1, 3) : $urandom_range(1, span + 10);
         p  = 0;
         if (plant) begin
            rl = gen_len + $urandom_range(0, 10);
            p  = $urandom_range(0, rl - gen_len);
         end
         for (int i = 0; i < rl; i++) begin
            b = rand_byte();
            if (plant && i >= p && i < p + gen_len && gen_care[i-p]) b = gen_pat[i-p];
            cmd = (i == 0 && $urandom_range(19) != 0) ? CMD_REGION : CMD_BYTE;
            push(cmd, b, base + ADDR_W'(i));
         end
      end
      if ($urandom_range(9) != 0) push(CMD_END, rand_byte(), rand_addr());
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3))
            push(command_type'($urandom_range(3)), rand_byte(), rand_addr());
      end
   endtask

   task automatic pick_config(int phase);
      logic [63:0] w [4];
      logic [31:0] care;
      int len, r;
      foreach (w[i]) w[i] = {$urandom, $urandom};
      if (phase == 4) foreach (w[i]) w[i] = '1;
      if (phase == 5) foreach (w[i]) w[i] = '0;
      r = $urandom_range(9);
      care = (r < 3) ? '1 : (r == 3) ? '0 : $urandom;
      r = $urandom_range(99);
      if (r < 60)      len = $urandom_range(1, 6);
      else if (r < 80) len = $urandom_range(7, 16);
      else if (r < 90) len = $urandom_range(17, 32);
      else if (r < 95) len = 0;
      else             len = $urandom_range(33, 63);
      case (phase)
         0: begin len = 32; care = '1; end
         1: len = 1;
         3: len = 0;
         7: len = 63;
         default: ;
      endcase
      apply_config(w, care, 6'(len));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: A x F pattern, middle byte a wildcard, unused bytes and care bits set
      apply_config('{64'h3333_3333_33FF_5CAA, '1, '1, '1}, 32'hFFFF_FFF5, 6'd3);
      push(CMD_BYTE,   8'h11, 48'h10);     // bytes ahead of any start still scan
      push(CMD_BYTE,   8'hAA, 48'h11);
      push(CMD_BYTE,   8'h55, 48'h12);
      push(CMD_BYTE,   8'hFF, 48'h13);
      push(CMD_BYTE,   8'hAA, 48'h14);     // ignored while done
      push(CMD_REGION, 8'hAA, 48'h15);
      push(CMD_END,    8'h00, 48'h0);
      push(CMD_START,  8'hFF, '1);
      push(CMD_REGION, 8'hAA, '1);         // match address wraps below zero
      push(CMD_BYTE,   8'h00, 48'h0);
      push(CMD_BYTE,   8'hFF, 48'h1);
      push(CMD_START,  8'h00, 48'h0);
      push(CMD_REGION, 8'hAA, 48'h100);
      push(CMD_BYTE,   8'h7E, 48'h101);
      push(CMD_REGION, 8'hFF, 48'h200);    // region boundary breaks the window
      push(CMD_BYTE,   8'h00, 48'h201);
      push(CMD_END,    8'hFF, '1);
      push(CMD_END,    8'h00, 48'h0);
      push(CMD_START,  8'h00, 48'h0);
      push(CMD_END,    8'h00, 48'h0);
      drive_items(0);
      wait_drained();

      // zero length never matches
      apply_config('{'0, '0, '0, '0}, '0, 6'd0);
      push(CMD_START,  8'h00, 48'h0);
      push(CMD_REGION, 8'h00, 48'h0);
      push(CMD_BYTE,   8'h00, 48'h1);
      push(CMD_END,    8'h00, 48'h0);
      drive_items(0);
      wait_drained();

      // oversized length never matches either
      apply_config('{'1, '1, '1, '1}, '0, 6'd63);
      push(CMD_START,  8'h00, 48'h0);
      push(CMD_REGION, 8'hFF, 48'h40);
      push(CMD_BYTE,   8'hFF, 48'h41);
      push(CMD_END,    8'h00, 48'h0);
      drive_items(0);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         pick_config(ph);
         while (stim_q.size() < PHASE_ITEMS) gen_scan(ph == PRESSURE_PHASE);
         if (ph == PRESSURE_PHASE) begin
            // receiver goes quiet while the sender keeps pushing short scans
            rsp_stall_pct = 0;
            rsp_hold_len  = HOLD_CYCLES;
            drive_items(0);
         end else begin
            case (ph % 4)
               0: begin rsp_stall_pct = 0;  drive_items(0);  end
               1: begin rsp_stall_pct = 0;  drive_items(74); end
               2: begin rsp_stall_pct = 74; drive_items(0);  end
               default: begin rsp_stall_pct = 29; drive_items(29); end
            endcase
         end
         wait_drained();
      end

      $display("run covered %0d input transactions under %0d pattern settings",
               sb.accepted, config_count);
      $display("%0d results checked, %0d of them matches, %0d mismatches",
               sb.results, sb.match_count, sb.errors);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
